@@ rtl/core/signed_int_to_four_digit_segments_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the signed integer to four-digit segment encoder
// Shared helpers that keep the checker's properties short and uniform.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_FOUR_DIGIT_SEGMENTS_DEFINES_SVH
`define SIGNED_INT_TO_FOUR_DIGIT_SEGMENTS_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SEG4_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SEG4_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that is checked during reset as well.
`define SEG4_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/seg4_pkg.sv @@
// ----------------------------------------------------------------------------
// seg4_pkg
// Types, constants and the digit glyph table of the four-digit encoder.
// ----------------------------------------------------------------------------
package seg4_pkg;

   localparam int unsigned THOUSAND = 1000;
   localparam int unsigned HUNDRED  = 100;
   localparam int unsigned TEN      = 10;

   // Largest magnitudes that fit the four positions.
   localparam logic [15:0] MAX_POS_MAG = 16'(9999);
   localparam logic [15:0] MAX_NEG_MAG = 16'(THOUSAND - 1);

   // Reciprocals for quotients of magnitudes below 10000; each one is exact
   // over that range after truncation.
   localparam logic [27:0] RECIP_1000 = 28'd8389; // >> 23
   localparam logic [27:0] RECIP_100  = 28'd5243; // >> 19
   localparam logic [27:0] RECIP_10   = 28'd6554; // >> 16

   localparam logic [6:0] SEG_MINUS = 7'h40;
   localparam logic [6:0] SEG_BLANK = 7'h00;

   // Quotients of one value, passed from the divide stage to the glyph stage.
   typedef struct packed {
      logic        in_range;
      logic        neg;
      logic [13:0] mag;
      logic [3:0]  q1000;
      logic [6:0]  q100;
      logic [9:0]  q10;
   } quot_type;

   function automatic logic [6:0] digit_seg(input logic [3:0] digit);
      logic [6:0] seg;
      unique case (digit)
         4'd0: seg = 7'h3F;
         4'd1: seg = 7'h06;
         4'd2: seg = 7'h5B;
         4'd3: seg = 7'h4F;
         4'd4: seg = 7'h66;
         4'd5: seg = 7'h6D;
         4'd6: seg = 7'h7D;
         4'd7: seg = 7'h07;
         4'd8: seg = 7'h7F;
         4'd9: seg = 7'h6F;
         default: seg = SEG_BLANK;
      endcase
      return seg;
   endfunction

endpackage

@@ rtl/core/seg4_ifs.sv @@
// ----------------------------------------------------------------------------
// seg4_req_if / seg4_rsp_if
// Valid/ready channels for input values and output glyph beats.
// ----------------------------------------------------------------------------
interface seg4_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface seg4_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] position;
   logic [6:0] segments;
   logic       last_glyph;

   modport source (output valid, output position, output segments, output last_glyph,
                   input ready);
   modport sink   (input valid, input position, input segments, input last_glyph,
                   output ready);
endinterface

@@ rtl/core/seg4_split.sv @@
// ----------------------------------------------------------------------------
// seg4_split
// Input register, magnitude and range check, and decimal quotient register.
// ----------------------------------------------------------------------------
module seg4_split (
   input  logic               clock,
   input  logic               reset,
   seg4_req_if.sink           req_bus,
   output logic               q_valid,
   input  logic               q_ready,
   output seg4_pkg::quot_type q_out
);

   logic               v_valid_ff, v_valid_in;
   logic signed [15:0] value_ff, value_in;
   logic               q_valid_ff, q_valid_in;
   seg4_pkg::quot_type q_ff, q_in;

   logic               s2_ready;
   logic               neg;
   logic [15:0]        mag16;
   logic [13:0]        mag;
   logic [27:0]        p1000, p100, p10;
   seg4_pkg::quot_type q_calc;

   assign s2_ready      = !q_valid_ff || q_ready;
   assign req_bus.ready = !v_valid_ff || s2_ready;

   always_comb begin
      neg   = value_ff[15];
      mag16 = neg ? (~value_ff + 16'd1) : value_ff;
      mag   = mag16[13:0];
      p1000 = 28'(mag) * seg4_pkg::RECIP_1000;
      p100  = 28'(mag) * seg4_pkg::RECIP_100;
      p10   = 28'(mag) * seg4_pkg::RECIP_10;

      q_calc.in_range = neg ? (mag16 <= seg4_pkg::MAX_NEG_MAG)
                            : (mag16 <= seg4_pkg::MAX_POS_MAG);
      q_calc.neg      = neg;
      q_calc.mag      = mag;
      q_calc.q1000    = p1000[26:23];
      q_calc.q100     = p100[25:19];
      q_calc.q10      = p10[25:16];
   end

   always_comb begin
      v_valid_in = req_bus.ready ? req_bus.valid : v_valid_ff;
      value_in   = (req_bus.valid && req_bus.ready) ? req_bus.value : value_ff;
      q_valid_in = s2_ready ? v_valid_ff : q_valid_ff;
      q_in       = (s2_ready && v_valid_ff) ? q_calc : q_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_valid_ff <= 1'b0;
         q_valid_ff <= 1'b0;
      end else begin
         v_valid_ff <= v_valid_in;
         q_valid_ff <= q_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      q_ff     <= q_in;
   end

   assign q_valid = q_valid_ff;
   assign q_out   = q_ff;

endmodule

@@ rtl/core/seg4_glyph.sv @@
// ----------------------------------------------------------------------------
// seg4_glyph
// Digit extraction, glyph sequencer and result register.
// ----------------------------------------------------------------------------
module seg4_glyph (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_ready,
   input  seg4_pkg::quot_type q_in,
   seg4_rsp_if.source         rsp_bus
);

   logic             em_valid_ff, em_valid_in;
   logic [1:0]       pos_ff, pos_in;
   logic             minus_ff, minus_in;
   logic [3:0][3:0]  digits_ff, digits_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_pos_ff, rsp_pos_in;
   logic [6:0]       rsp_seg_ff, rsp_seg_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             out_free, fire, done, em_ready, load;
   logic [6:0]       ten_q1000, d1_w;
   logic [9:0]       ten_q100, d2_w;
   logic [13:0]      ten_q10, d3_w;
   logic [3:0][3:0]  digits_calc;
   logic [1:0]       dstart, first_pos;
   logic [6:0]       glyph_seg;

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign fire     = em_valid_ff && out_free;
   assign done     = fire && (pos_ff == 2'd3);
   assign em_ready = !em_valid_ff || done;
   assign load     = q_valid && q_in.in_range && em_ready;
   // Values that cannot be shown leave the pipeline without any glyph.
   assign q_ready  = !q_in.in_range || em_ready;

   always_comb begin
      ten_q1000 = {q_in.q1000, 3'b000} + {2'b00, q_in.q1000, 1'b0};
      ten_q100  = {q_in.q100, 3'b000} + {2'b00, q_in.q100, 1'b0};
      ten_q10   = {1'b0, q_in.q10, 3'b000} + {3'b000, q_in.q10, 1'b0};
      d1_w      = q_in.q100 - ten_q1000;
      d2_w      = q_in.q10 - ten_q100;
      d3_w      = q_in.mag - ten_q10;

      digits_calc[0] = q_in.q1000;
      digits_calc[1] = d1_w[3:0];
      digits_calc[2] = d2_w[3:0];
      digits_calc[3] = d3_w[3:0];

      priority if (q_in.q1000 != 4'd0) begin
         dstart = 2'd0;
      end else if (q_in.q100 != 7'd0) begin
         dstart = 2'd1;
      end else if (q_in.q10 != 10'd0) begin
         dstart = 2'd2;
      end else begin
         dstart = 2'd3;
      end
      // A shown negative value never has four digits, so this cannot wrap.
      first_pos = dstart - {1'b0, q_in.neg};
   end

   always_comb begin
      glyph_seg = minus_ff ? seg4_pkg::SEG_MINUS : seg4_pkg::digit_seg(digits_ff[pos_ff]);

      em_valid_in = em_valid_ff;
      pos_in      = pos_ff;
      minus_in    = minus_ff;
      digits_in   = digits_ff;
      if (fire) begin
         pos_in   = pos_ff + 2'd1;
         minus_in = 1'b0;
      end
      if (done) begin
         em_valid_in = 1'b0;
      end
      if (load) begin
         em_valid_in = 1'b1;
         pos_in      = first_pos;
         minus_in    = q_in.neg;
         digits_in   = digits_calc;
      end

      rsp_valid_in = fire ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
      rsp_pos_in   = fire ? pos_ff : rsp_pos_ff;
      rsp_seg_in   = fire ? glyph_seg : rsp_seg_ff;
      rsp_last_in  = fire ? (pos_ff == 2'd3) : rsp_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         em_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         em_valid_ff  <= em_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      minus_ff    <= minus_in;
      digits_ff   <= digits_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_seg_ff  <= rsp_seg_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.position   = rsp_pos_ff;
   assign rsp_bus.segments   = rsp_seg_ff;
   assign rsp_bus.last_glyph = rsp_last_ff;

endmodule

@@ rtl/core/signed_int_to_four_digit_segments.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_four_digit_segments
// Turns a signed 16-bit value into the glyphs of a right-aligned 4-digit
// seven-segment display, one glyph per output beat, left to right.
// ----------------------------------------------------------------------------
// Usage:
// A value enters on req_bus as one beat. Values from -999 to 9999 produce one
// rsp_bus beat per lit position: an optional minus sign just left of the most
// significant digit, then the digits without leading zeros. The beat for the
// rightmost position (position 3) carries last_glyph. Values outside that
// range are consumed and produce no beats at all.
// The first glyph of a value reaches the output after its input beat is
// accepted, through the input register, the quotient register and the
// glyph sequencer feeding the result register.
// Throughput: while rsp_bus.ready stays high, the result register sends one
// glyph per cycle, one beat for each glyph of a value; the next value is
// taken in while earlier glyphs are still leaving.
// When the receiver holds rsp_bus.ready low, the result beat holds and the
// stall backs up stage by stage until req_bus.ready drops.
// Reset clears all valid flags; no results are pending after reset.
// ----------------------------------------------------------------------------
module signed_int_to_four_digit_segments (
   input  logic       clock,
   input  logic       reset,
   seg4_req_if.sink   req_bus,
   seg4_rsp_if.source rsp_bus
);

   // Handshake between the divide stage and the glyph stage.
   logic               q_valid;
   logic               q_ready;
   seg4_pkg::quot_type q_data;

   // The divide stage registers the input value, forms its magnitude, checks
   // the displayable range and registers the quotients by 1000, 100 and 10,
   // each taken with a constant reciprocal multiply.
   seg4_split u_split (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_valid (q_valid),
      .q_ready (q_ready),
      .q_out   (q_data)
   );

   // The glyph stage recovers the four decimal digits from the quotients,
   // finds the leftmost lit position, and then steps through the positions
   // one beat at a time into the result register.
   seg4_glyph u_glyph (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_ready (q_ready),
      .q_in    (q_data),
      .rsp_bus (rsp_bus)
   );

endmodule

@@ rtl/core/seg4_chk.sv @@
// ----------------------------------------------------------------------------
// seg4_chk
// Port-level checks on the glyph stream of the four-digit encoder.
// ----------------------------------------------------------------------------
`include "signed_int_to_four_digit_segments_defines.svh"

module seg4_chk (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_position,
   input logic [6:0] rsp_segments,
   input logic       rsp_last_glyph
);

   logic       mid_ff, mid_in;
   logic [1:0] exp_pos_ff, exp_pos_in;
   logic       beat;

   assign beat = rsp_valid && rsp_ready;

   // Track whether the stream is inside a value and which position comes next.
   always_comb begin
      mid_in     = beat ? !rsp_last_glyph : mid_ff;
      exp_pos_in = beat ? (rsp_position + 2'd1) : exp_pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff     <= 1'b0;
         exp_pos_ff <= 2'd0;
      end else begin
         mid_ff     <= mid_in;
         exp_pos_ff <= exp_pos_in;
      end
   end

   `SEG4_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_position) && $stable(rsp_segments) && $stable(rsp_last_glyph), "stalled glyph beat changed")
   `SEG4_ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset, !rsp_valid, "result valid right after reset")
   `SEG4_ASSERT_IMPL(a_last_right, clock, reset, rsp_valid, rsp_last_glyph == (rsp_position == 2'd3), "last glyph flag not tied to rightmost position")
   `SEG4_ASSERT_IMPL(a_pos_step, clock, reset, rsp_valid && mid_ff, rsp_position == exp_pos_ff, "glyph positions of a value not consecutive")
   `SEG4_ASSERT_IMPL(a_minus_first, clock, reset, rsp_valid && mid_ff, rsp_segments != seg4_pkg::SEG_MINUS, "minus sign after the first glyph of a value")

endmodule

bind signed_int_to_four_digit_segments seg4_chk u_seg4_chk (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_position   (rsp_bus.position),
   .rsp_segments   (rsp_bus.segments),
   .rsp_last_glyph (rsp_bus.last_glyph)
);
